[hdl/sapm_pkg.sv]
// Shared types and constants for the serial ADC peak current meter.
// No dependencies; imported by every module of the block but sapm_queue.
`default_nettype none

package sapm_pkg;

    // Fixed field widths of the result stream and the config registers
    localparam int SAMPLE_W = 12;
    localparam int CUR_W    = 20;
    localparam int GAIN_W   = 24;
    localparam int WIN_W    = 32;
    localparam int CHAN_W   = 4;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;

    // Q8.16 gains: round to nearest before dropping the fraction
    localparam int FRAC_BITS = 16;
    localparam int ROUND_HALF = 32768;

    // Command: start and single-ended bits ahead of the channel bits
    localparam int CMD_BITS   = 5;
    localparam int SKIP_PULSE = 7;

    // Register reset values
    localparam logic [CHAN_W-1:0] RST_CHANNEL = 4'd1;
    localparam logic [WIN_W-1:0]  RST_WINDOW  = 32'd1000000;
    localparam logic [GAIN_W-1:0] RST_AMP_GAIN = 24'd2100000;
    localparam logic [GAIN_W-1:0] RST_EFF_GAIN = 24'd1489362;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ADC_CHANNEL    = 2'd0,
        CFG_WINDOW_TICKS   = 2'd1,
        CFG_AMPLITUDE_GAIN = 2'd2,
        CFG_EFFECTIVE_GAIN = 2'd3
    } t_cfg_idx;

    // Per-tick pin and event flags from the sequencer
    typedef struct packed {
        logic done;
        logic valid;
        logic mosi;
        logic sclk;
        logic cs_n;
    } t_tick_ctl;

    // One result request, last field in the lowest bits
    typedef struct packed {
        logic [CUR_W-1:0]    eff;
        logic [CUR_W-1:0]    amp;
        logic [SAMPLE_W-1:0] peak;
        logic                done;
        logic [SAMPLE_W-1:0] sample;
        logic                valid;
        logic                mosi;
        logic                sclk;
        logic                cs_n;
    } t_result;

endpackage

`default_nettype wire

[hdl/sapm_front.sv]
// Front end: conversion sequencer, data shift register and window counter.
// Depends on sapm_pkg.
`default_nettype none

module sapm_front #(
    parameter int ADC_BITS = 12
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_accept,
    input  wire logic                          i_miso,
    input  wire logic [sapm_pkg::CHAN_W-1:0]   i_channel,
    input  wire logic [sapm_pkg::WIN_W-1:0]    i_window_ticks,
    output sapm_pkg::t_tick_ctl                o_ctl,
    output logic [ADC_BITS-1:0]                o_sample
);
    import sapm_pkg::*;

    localparam int PULSES     = 7 + ADC_BITS;
    localparam int CONV_TICKS = 2 * PULSES + 2;
    localparam int PH_W       = $clog2(CONV_TICKS);

    logic [PH_W-1:0]     r_phase, n_phase;
    logic [ADC_BITS-1:0] r_shift, n_shift;
    logic [WIN_W-1:0]    r_elapsed, n_elapsed;

    logic [PH_W-1:0]     tm1;
    logic [PH_W-2:0]     pulse;
    logic                high;
    logic                last_tick;
    logic [WIN_W-1:0]    elapsed_inc;
    logic [2:0]          chan_m1;
    logic [CMD_BITS-1:0] cmd;

    always_comb begin
        tm1         = r_phase - PH_W'(1);
        pulse       = tm1[PH_W-1:1];
        high        = tm1[0];
        last_tick   = (r_phase == PH_W'(CONV_TICKS - 1));
        elapsed_inc = (r_elapsed == '1) ? r_elapsed : r_elapsed + WIN_W'(1);
        chan_m1     = 3'(i_channel - CHAN_W'(1));
        cmd         = {2'b11, chan_m1};

        o_ctl     = '0;
        o_sample  = '0;
        n_shift   = r_shift;
        n_elapsed = elapsed_inc;
        n_phase   = last_tick ? '0 : r_phase + PH_W'(1);

        if (r_phase == '0) begin
            n_shift = '0;
        end else if (!last_tick) begin
            o_ctl.sclk = high;
            if (pulse < (PH_W-1)'(CMD_BITS)) begin
                o_ctl.mosi = cmd[3'(CMD_BITS - 1) - pulse[2:0]];
            end else if (pulse >= (PH_W-1)'(SKIP_PULSE) && !high) begin
                n_shift = {r_shift[ADC_BITS-2:0], i_miso};
            end
        end else begin
            o_ctl.cs_n  = 1'b1;
            o_ctl.valid = 1'b1;
            o_sample    = r_shift;
            if (elapsed_inc >= i_window_ticks) begin
                o_ctl.done = 1'b1;
                n_elapsed  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= '0;
            r_shift   <= '0;
            r_elapsed <= '0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_shift   <= n_shift;
            r_elapsed <= n_elapsed;
        end
    end

endmodule

`default_nettype wire

[hdl/sapm_queue.sv]
// Two-entry request queue between the sequencer and the peak/scale back end.
// Does not depend on sapm_pkg; data width is a parameter.
`default_nettype none

module sapm_queue #(
    parameter int DATA_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_data,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic                   o_empty,
    output logic [DATA_W-1:0]      o_data
);
    logic [DATA_W-1:0] r_mem [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_count, n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= ~r_wr_ptr;
            if (i_pop)  r_rd_ptr <= ~r_rd_ptr;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

[hdl/sapm_back.sv]
// Back end: peak hold, then Q8.16 current scaling into the output register.
// Depends on sapm_pkg.
`default_nettype none

module sapm_back #(
    parameter int ADC_BITS = 12
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_q_empty,
    input  wire sapm_pkg::t_tick_ctl           i_q_ctl,
    input  wire logic [ADC_BITS-1:0]           i_q_sample,
    output logic                               o_q_pop,
    input  wire logic [sapm_pkg::GAIN_W-1:0]   i_amp_gain,
    input  wire logic [sapm_pkg::GAIN_W-1:0]   i_eff_gain,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output sapm_pkg::t_result                  o_result
);
    import sapm_pkg::*;

    localparam int ACC_W = (ADC_BITS + GAIN_W + 1 > FRAC_BITS + CUR_W) ?
                           ADC_BITS + GAIN_W + 1 : FRAC_BITS + CUR_W;

    // Stage A: peak update
    logic                r_a_valid;
    t_tick_ctl           r_a_ctl;
    logic [ADC_BITS-1:0] r_a_sample;
    logic [ADC_BITS-1:0] r_a_peak;
    logic [ADC_BITS-1:0] r_peak, n_peak, peak_max;

    // Stage B: output register
    logic                r_b_valid;
    t_result             r_b;
    t_result             n_b;
    logic [ACC_W-1:0]    amp_acc, eff_acc;

    logic a_adv, b_adv;

    assign b_adv   = !r_b_valid || i_ready;
    assign a_adv   = !r_a_valid || b_adv;
    assign o_q_pop = !i_q_empty && a_adv;

    always_comb begin
        peak_max = (i_q_sample > r_peak) ? i_q_sample : r_peak;
        n_peak   = r_peak;
        if (i_q_ctl.valid) n_peak = peak_max;
        if (i_q_ctl.done)  n_peak = '0;
    end

    always_comb begin
        amp_acc = ACC_W'(r_a_peak) * ACC_W'(i_amp_gain) + ACC_W'(ROUND_HALF);
        eff_acc = ACC_W'(r_a_peak) * ACC_W'(i_eff_gain) + ACC_W'(ROUND_HALF);
        n_b        = '0;
        n_b.cs_n   = r_a_ctl.cs_n;
        n_b.sclk   = r_a_ctl.sclk;
        n_b.mosi   = r_a_ctl.mosi;
        n_b.valid  = r_a_ctl.valid;
        n_b.sample = SAMPLE_W'(r_a_sample);
        n_b.done   = r_a_ctl.done;
        n_b.peak   = SAMPLE_W'(r_a_peak);
        n_b.amp    = amp_acc[FRAC_BITS +: CUR_W];
        n_b.eff    = eff_acc[FRAC_BITS +: CUR_W];
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_a_ctl    <= i_q_ctl;
            r_a_sample <= i_q_sample;
            r_a_peak   <= i_q_ctl.done ? peak_max : '0;
        end
        if (r_a_valid && b_adv) begin
            r_b <= n_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_peak    <= '0;
        end else begin
            if (a_adv)  r_a_valid <= !i_q_empty;
            if (b_adv)  r_b_valid <= r_a_valid;
            if (o_q_pop) r_peak   <= n_peak;
        end
    end

    assign o_valid  = r_b_valid;
    assign o_result = r_b;

endmodule

`default_nettype wire

[hdl/spi_adc_peak_current_meter.sv]
// Top level of the serial ADC peak current meter: config registers, front
// sequencer, request queue and back end. Depends on sapm_pkg and all sapm_* modules.
//
//  Channel   Dir  Payload                                     Handshake
//  s_axis    in   tdata[0] miso_bit, [7:1] zero               tvalid/tready
//  m_axis    out  tdata: cs_n, sclk, mosi, sample_valid,      tvalid/tready
//                 sample, window_done, peak, amp, eff
//  cfg       in   index (2b), data (32b)                      write enable only
//
// One request in and one result request out per clock while the output is
// not stalled; the sequencer steps once per accepted tick and the back end
// is two registers. The accepting edge writes the queue; the result then
// passes the peak stage and the scaling multiply into the output register,
// where it is presented.
// Reset is synchronous, active low, and clears the tick phase, window count,
// peak and all valid flags; the config registers take their reset values.
// An output stall backs up into the two-entry queue; tready drops when full.
`default_nettype none

module spi_adc_peak_current_meter #(
    parameter int ADC_BITS = 12
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // configuration write port
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [sapm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [sapm_pkg::CFG_W-1:0]       i_cfg_data,
    // tick requests: [0] miso_bit, [7:1] zero
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  wire logic [7:0]                       i_s_axis_tdata,
    // results: [0] chip_select_n, [1] serial_clock, [2] mosi_bit,
    // [3] sample_valid, [15:4] sample_value, [16] window_done,
    // [28:17] peak_value, [48:29] amplitude_tenths_ma,
    // [68:49] effective_tenths_ma, [71:69] zero
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    output logic [71:0]                           o_m_axis_tdata
);
    import sapm_pkg::*;

    localparam int Q_W = $bits(t_tick_ctl) + ADC_BITS;

    // Configuration registers
    logic [CHAN_W-1:0] r_channel;
    logic [WIN_W-1:0]  r_window_ticks;
    logic [GAIN_W-1:0] r_amp_gain;
    logic [GAIN_W-1:0] r_eff_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel      <= RST_CHANNEL;
            r_window_ticks <= RST_WINDOW;
            r_amp_gain     <= RST_AMP_GAIN;
            r_eff_gain     <= RST_EFF_GAIN;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ADC_CHANNEL:    r_channel      <= CHAN_W'(i_cfg_data);
                CFG_WINDOW_TICKS:   r_window_ticks <= i_cfg_data;
                CFG_AMPLITUDE_GAIN: r_amp_gain     <= GAIN_W'(i_cfg_data);
                CFG_EFFECTIVE_GAIN: r_eff_gain     <= GAIN_W'(i_cfg_data);
            endcase
        end
    end

    // Front: one tick per accepted request
    logic                in_accept;
    logic                q_full, q_empty, q_pop;
    t_tick_ctl           f_ctl;
    logic [ADC_BITS-1:0] f_sample;
    logic [Q_W-1:0]      q_out;
    t_tick_ctl           q_ctl;
    logic [ADC_BITS-1:0] q_sample;
    t_result             result;

    assign o_s_axis_tready = !q_full;
    assign in_accept       = i_s_axis_tvalid && !q_full;

    sapm_front #(.ADC_BITS(ADC_BITS)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_accept),
        .i_miso         (i_s_axis_tdata[0]),
        .i_channel      (r_channel),
        .i_window_ticks (r_window_ticks),
        .o_ctl          (f_ctl),
        .o_sample       (f_sample)
    );

    sapm_queue #(.DATA_W(Q_W)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_data  ({f_ctl, f_sample}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_out)
    );

    assign q_ctl    = q_out[Q_W-1:ADC_BITS];
    assign q_sample = q_out[ADC_BITS-1:0];

    sapm_back #(.ADC_BITS(ADC_BITS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_q_ctl    (q_ctl),
        .i_q_sample (q_sample),
        .o_q_pop    (q_pop),
        .i_amp_gain (r_amp_gain),
        .i_eff_gain (r_eff_gain),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_result   (result)
    );

    assign o_m_axis_tdata = {3'b000, result};

`ifndef SYNTHESIS
    // A finished sample only appears on the chip-select release tick
    a_sample_on_cs_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[3] |-> o_m_axis_tdata[0] && !o_m_axis_tdata[1])
        else $error("sample reported while chip select is low");

    // A window can only close on a conversion end
    a_done_needs_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[16] |-> o_m_axis_tdata[3])
        else $error("window closed without a sample");

    // Command bits are driven only while chip select is low
    a_mosi_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[2] |-> !o_m_axis_tdata[0])
        else $error("command bit outside the conversion frame");

    // Queue stays full while nothing drains the output
    a_stall_holds_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready && o_m_axis_tvalid && !i_m_axis_tready |=> !o_s_axis_tready)
        else $error("input reopened while output stalled");
`endif

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking bench for spi_adc_peak_current_meter: drives SPI ticks, models
// the serial ADC sequencer and peak/current scaling, and checks every result.
// Depends on sapm_pkg and the spi_adc_peak_current_meter RTL.
`timescale 1ns / 100ps

module tb;
    import sapm_pkg::*;

    localparam int ADC_BITS    = 12;
    localparam int PULSES      = 7 + ADC_BITS;
    localparam int CONV_TICKS  = 2 * PULSES + 2;   // ticks per conversion
    localparam int RANDOM_TICKS = 40;               // random-phase tick budget
    localparam int DRAIN_EXTRA = 6;                 // extra drain beyond the pipeline
    localparam int SINK_HOLD   = 150;               // long output stall, cycles
    localparam int STALL_LIMIT = 2000;              // watchdog, idle cycles

    // DUT pins
    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_s_axis_tvalid;
    logic                 o_s_axis_tready;
    logic [7:0]           i_s_axis_tdata;   // [0] miso_bit, [7:1] zero
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready;
    // [0] cs_n, [1] sclk, [2] mosi, [3] sample_valid, [15:4] sample,
    // [16] window_done, [28:17] peak, [48:29] amplitude, [68:49] effective
    logic [71:0]          o_m_axis_tdata;

    spi_adc_peak_current_meter #(
        .ADC_BITS(ADC_BITS)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Meter model: register copies and sequencer / peak state
    // ------------------------------------------------------------------
    logic [CHAN_W-1:0]   chan_reg     = RST_CHANNEL;
    logic [WIN_W-1:0]    window_reg   = RST_WINDOW;
    logic [GAIN_W-1:0]   amp_gain_reg = RST_AMP_GAIN;
    logic [GAIN_W-1:0]   eff_gain_reg = RST_EFF_GAIN;

    int unsigned         tick_phase = 0;    // tick within the conversion
    logic [ADC_BITS-1:0] shift_reg  = '0;   // MISO shift register
    logic [ADC_BITS-1:0] peak_reg   = '0;   // peak of the open window
    logic [WIN_W-1:0]    elapsed    = '0;   // ticks since window start, saturating

    t_result expected_q[$];                 // results owed by the DUT, oldest first

    // Bookkeeping
    bit          src_idle_on   = 1'b1;
    bit          sink_idle_on  = 1'b1;
    bit          sink_hold_req = 1'b0;
    int unsigned tick_cnt      = 0;
    int unsigned result_cnt    = 0;
    int unsigned window_cnt    = 0;
    int unsigned err_cnt       = 0;
    int unsigned stall_cycles  = 0;

    // Q8.16 gain applied to the peak, rounded to nearest
    function automatic logic [CUR_W-1:0] q16_current(logic [ADC_BITS-1:0] peak,
                                                     logic [GAIN_W-1:0] gain);
        logic [39:0] prod;
        prod = 40'(peak) * 40'(gain) + 40'(ROUND_HALF);
        return prod[FRAC_BITS +: CUR_W];
    endfunction

    // Advance the model by one tick and return the result it produces
    function automatic t_result meter_tick(bit miso);
        t_result     r;
        int unsigned pulse;
        bit          clk_high;
        logic [7:0]  cmd;
        logic [2:0]  chan_code;
        r = '0;
        chan_code = 3'(chan_reg - 4'd1);             // channel wraps mod 8
        cmd = {2'b11, chan_code, 3'b000};            // start, single-ended, channel
        if (elapsed != '1)
            elapsed++;
        if (tick_phase == 0) begin
            shift_reg = '0;                          // cs_n falls, clock idle low
        end else if (tick_phase < CONV_TICKS - 1) begin
            pulse    = (tick_phase - 1) / 2;
            clk_high = ((tick_phase - 1) % 2) != 0;
            r.sclk   = clk_high;
            if (pulse < CMD_BITS)
                r.mosi = cmd[7 - pulse];
            else if (pulse >= SKIP_PULSE && !clk_high)
                shift_reg = {shift_reg[ADC_BITS-2:0], miso};
        end else begin
            // closing tick: sample out, peak update, maybe window report
            r.cs_n   = 1'b1;
            r.valid  = 1'b1;
            r.sample = shift_reg;
            if (shift_reg > peak_reg)
                peak_reg = shift_reg;
            if (elapsed >= window_reg) begin
                r.done   = 1'b1;
                r.peak   = peak_reg;
                r.amp    = q16_current(peak_reg, amp_gain_reg);
                r.eff    = q16_current(peak_reg, eff_gain_reg);
                peak_reg = '0;
                elapsed  = '0;
            end
        end
        tick_phase = (tick_phase + 1 >= CONV_TICKS) ? 0 : tick_phase + 1;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_wr_en     <= 1'b0;
        i_cfg_index     <= CFG_ADC_CHANNEL;
        i_cfg_data      <= '0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
    end

    // Register write; only called with the pipeline drained
    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_W-1:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_ADC_CHANNEL:    chan_reg     = value[CHAN_W-1:0];
            CFG_WINDOW_TICKS:   window_reg   = value[WIN_W-1:0];
            CFG_AMPLITUDE_GAIN: amp_gain_reg = value[GAIN_W-1:0];
            CFG_EFFECTIVE_GAIN: eff_gain_reg = value[GAIN_W-1:0];
        endcase
    endtask

    // One tick request; tvalid stays high on return so back-to-back ticks flow
    task automatic send_tick(input bit miso);
        if (src_idle_on && $urandom_range(0, 4) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {7'b0, miso};
        do @(posedge i_clk); while (!o_s_axis_tready);
        expected_q.push_back(meter_tick(miso));
        tick_cnt++;
    endtask

    // Ticks up to the next conversion boundary; MISO carries value on the
    // sampling ticks, random noise elsewhere
    task automatic send_conversion(input logic [ADC_BITS-1:0] value);
        int unsigned pulse;
        bit          b;
        do begin
            b = 1'($urandom_range(0, 1));
            if (tick_phase % 2 == 1 && tick_phase < CONV_TICKS - 1) begin
                pulse = (tick_phase - 1) / 2;
                if (pulse >= SKIP_PULSE)
                    b = value[ADC_BITS - 1 - (pulse - SKIP_PULSE)];
            end
            send_tick(b);
        end while (tick_phase != 0);
    endtask

    // Sender pauses until every owed result has come, plus pipeline slack
    task automatic wait_results_drained();
        i_s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_EXTRA) @(posedge i_clk);
    endtask

    // Result sink: random stall bursts, or one long hold on request
    initial begin
        i_m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                i_m_axis_tready <= 1'b0;
                repeat (SINK_HOLD) @(posedge i_clk);
                i_m_axis_tready <= 1'b1;
            end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
                i_m_axis_tready <= 1'b1;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    function automatic void check_field(string name, logic [CUR_W-1:0] want,
                                        logic [CUR_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            err_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = o_m_axis_tdata[$bits(t_result)-1:0];
            if (expected_q.size() == 0) begin
                $error("result with nothing expected: tdata %h", o_m_axis_tdata);
                err_cnt++;
            end else begin
                want = expected_q.pop_front();
                result_cnt++;
                if (want.done)
                    window_cnt++;
                check_field("chip_select_n", CUR_W'(want.cs_n), CUR_W'(got.cs_n));
                check_field("serial_clock", CUR_W'(want.sclk), CUR_W'(got.sclk));
                check_field("mosi_bit", CUR_W'(want.mosi), CUR_W'(got.mosi));
                check_field("sample_valid", CUR_W'(want.valid), CUR_W'(got.valid));
                check_field("sample_value", CUR_W'(want.sample), CUR_W'(got.sample));
                check_field("window_done", CUR_W'(want.done), CUR_W'(got.done));
                check_field("peak_value", CUR_W'(want.peak), CUR_W'(got.peak));
                check_field("amplitude_tenths_ma", want.amp,    got.amp);
                check_field("effective_tenths_ma", want.eff,    got.eff);
            end
        end
    end

    // Watchdog: too long without any request moving on either side
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no request moved for %0d cycles", STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset register values: channel 1, window far away, no report yet.
    // Full-scale then zero sample; the peak of 4095 is carried forward.
    task automatic test_reset_defaults();
        send_conversion('1);
        send_conversion('0);
        wait_results_drained();
    endtask

    // Channel numbers outside 1..8 wrap: 0 -> code 7, 9 -> code 0, 15 -> code 6
    task automatic test_channel_wrap();
        cfg_write(CFG_ADC_CHANNEL, 32'd0);
        send_conversion(12'h800);
        wait_results_drained();
        cfg_write(CFG_ADC_CHANNEL, 32'd8);
        send_conversion(12'h001);
        wait_results_drained();
        cfg_write(CFG_ADC_CHANNEL, 32'd15);
        send_conversion(12'hAAA);
        wait_results_drained();
        cfg_write(CFG_ADC_CHANNEL, 32'd9);
        send_conversion(12'h555);
        wait_results_drained();
    endtask

    // Window zero reports every conversion; closing tick counts toward the
    // window (40 reports each conversion, 41 every other); max window never
    // reports. Gains at both extremes; equal samples leave the peak alone.
    task automatic test_window_edges();
        cfg_write(CFG_AMPLITUDE_GAIN, 32'hFF_FFFF);
        cfg_write(CFG_EFFECTIVE_GAIN, 32'd0);
        cfg_write(CFG_WINDOW_TICKS, 32'd0);
        send_conversion('0);                       // reports the 4095 peak
        wait_results_drained();
        cfg_write(CFG_AMPLITUDE_GAIN, 32'd0);
        cfg_write(CFG_EFFECTIVE_GAIN, 32'hFF_FFFF);
        cfg_write(CFG_WINDOW_TICKS, 32'd41);
        send_conversion(12'd5);
        send_conversion(12'd5);
        wait_results_drained();
        cfg_write(CFG_WINDOW_TICKS, 32'd40);
        send_conversion(12'd3);
        wait_results_drained();
        cfg_write(CFG_WINDOW_TICKS, 32'hFFFF_FFFF);
        send_conversion('1);
        wait_results_drained();
    endtask

    // Long result stall while ticks keep coming: the queue fills, tready drops
    task automatic test_output_stall();
        cfg_write(CFG_WINDOW_TICKS, 32'd40);
        cfg_write(CFG_AMPLITUDE_GAIN, 32'(RST_AMP_GAIN));
        cfg_write(CFG_EFFECTIVE_GAIN, 32'(RST_EFF_GAIN));
        sink_hold_req = 1'b1;
        send_conversion(12'd1234);
        send_conversion(12'd4000);
        send_conversion(12'd17);
        wait_results_drained();
    endtask

    // Random phases: fresh registers, a few conversions with random samples,
    // sometimes preceded by a broken fragment of a conversion; then a tail
    // with no idling on either side
    task automatic test_random_windows();
        int unsigned      start_ticks;
        logic [CFG_W-1:0] win;
        logic [CFG_W-1:0] gain;
        logic [ADC_BITS-1:0] value;
        start_ticks = tick_cnt;
        while (tick_cnt - start_ticks < RANDOM_TICKS) begin
            src_idle_on  = $urandom_range(0, 3) != 0;
            sink_idle_on = $urandom_range(0, 3) != 0;
            wait_results_drained();
            cfg_write(CFG_ADC_CHANNEL, 32'($urandom_range(0, 15)));
            case ($urandom_range(0, 7))
                0:       win = '0;
                1:       win = '1;
                2:       win = $urandom;
                default: win = $urandom_range(0, 200);
            endcase
            cfg_write(CFG_WINDOW_TICKS, win);
            repeat (2) begin
                case ($urandom_range(0, 5))
                    0:       gain = '0;
                    1:       gain = 32'hFF_FFFF;
                    default: gain = $urandom_range(0, 24'hFF_FFFF);
                endcase
                if ($urandom_range(0, 1) == 0)
                    cfg_write(CFG_AMPLITUDE_GAIN, gain);
                else
                    cfg_write(CFG_EFFECTIVE_GAIN, gain);
            end
            repeat ($urandom_range(1, 2)) begin
                if ($urandom_range(0, 5) == 0)
                    repeat ($urandom_range(1, CONV_TICKS - 1))
                        send_tick(1'($urandom_range(0, 1)));
                case ($urandom_range(0, 5))
                    0:       value = '0;
                    1:       value = '1;
                    default: value = ADC_BITS'($urandom_range(0, (1 << ADC_BITS) - 1));
                endcase
                send_conversion(value);
            end
        end
        // Tail: ticks and results flow back to back
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        send_conversion(ADC_BITS'($urandom_range(0, (1 << ADC_BITS) - 1)));
        wait_results_drained();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_channel_wrap();
        test_window_edges();
        test_output_stall();
        test_random_windows();

        if (expected_q.size() != 0) begin
            $error("%0d results never arrived", expected_q.size());
            err_cnt++;
        end
        $display("Run: %0d ticks, %0d results checked, %0d window reports;",
                 tick_cnt, result_cnt, window_cnt);
        $display("channel wrap, window 0/40/41/max, gain extremes, long stall swept.");
        if (err_cnt == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

[files.f]
hdl/sapm_pkg.sv
hdl/sapm_front.sv
hdl/sapm_queue.sv
hdl/sapm_back.sv
hdl/spi_adc_peak_current_meter.sv
tb/tb.sv
